@@ hw/rtl/sli_pkg.sv @@
`default_nettype none

package sli_pkg;

  localparam int unsigned ACTION_W = 1;
  localparam int unsigned LIST_SEL_W = 2;
  localparam int unsigned ITEM_ID_W = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned NEW_COUNT_W = 5;
  localparam int unsigned POSITION_W = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/sli_in_if.sv @@
`default_nettype none

interface sli_in_if;
  logic                              valid;
  logic                              ready;
  logic [sli_pkg::ACTION_W-1:0]      action;
  logic [sli_pkg::LIST_SEL_W-1:0]    list_sel;
  logic [sli_pkg::ITEM_ID_W-1:0]     item_id;

  modport source (output valid, action, list_sel, item_id, input ready);
  modport sink (input valid, action, list_sel, item_id, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sli_out_if.sv @@
`default_nettype none

interface sli_out_if;
  logic                              valid;
  logic                              ready;
  logic [sli_pkg::STATUS_W-1:0]      status;
  logic [sli_pkg::NEW_COUNT_W-1:0]   new_count;
  logic [sli_pkg::POSITION_W-1:0]    position;

  modport source (output valid, status, new_count, position, input ready);
  modport sink (input valid, status, new_count, position, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sorted_list_insert_remove.sv @@
// sequence: a request goes through S_SCAN, S_UPDATE and S_DONE to a registered
//   result; a missed remove skips S_UPDATE, a refused one goes to S_DONE
// throughput: one request at a time; the scan steps one slot per cycle along
//   the chain of cells, and S_DONE holds while the result side stalls
// reset: synchronous active low, clears all list counts and the handshakes;
//   stored entries are left as they are and never read beyond a count
`default_nettype none

module sorted_list_insert_remove #(
  parameter int unsigned LIST_DEPTH = 16,
  parameter int unsigned NUM_LISTS  = 3,
  parameter int unsigned ID_BITS    = 8
) (
  input  wire        clk,
  input  wire        rst_n,
  sli_in_if.sink     in_ch,
  sli_out_if.source  out_ch
);

  localparam int unsigned SLOT_W = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned SEL_W  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

  sli_pkg::state_t  state_r, state_nxt;
  sli_pkg::action_t act_r, act_nxt;
  logic [SEL_W-1:0]   sel_r, sel_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [CNT_W-1:0]   cnt_cur_r, cnt_cur_nxt;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [sli_pkg::STATUS_W-1:0]    res_status_r, res_status_nxt;
  logic [sli_pkg::NEW_COUNT_W-1:0] res_count_r, res_count_nxt;
  logic [sli_pkg::POSITION_W-1:0]  res_pos_r, res_pos_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [sli_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [sli_pkg::NEW_COUNT_W-1:0] out_count_r, out_count_nxt;
  logic [sli_pkg::POSITION_W-1:0]  out_pos_r, out_pos_nxt;
  logic [CNT_W-1:0]   cnt_r [NUM_LISTS];

  logic               in_xfer;
  logic               sel_ok;
  logic [SEL_W-1:0]   in_sel;
  logic [CNT_W-1:0]   in_cnt;
  logic               upd;
  logic               hit_sel;
  logic [CNT_W-1:0]   cnt_new;
  logic [ID_BITS-1:0] ent_sel [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] hit;

  assign in_ch.ready  = (state_r == sli_pkg::S_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign sel_ok       = (32'(in_ch.list_sel) < NUM_LISTS);
  assign in_sel       = SEL_W'(in_ch.list_sel);
  assign in_cnt       = sel_ok ? cnt_r[in_sel] : '0;
  assign upd          = (state_r == sli_pkg::S_UPDATE);
  assign hit_sel      = hit[scan_idx_r[SLOT_W-1:0]];
  assign cnt_new      = (act_r == sli_pkg::ACT_INSERT) ? cnt_cur_r + CNT_W'(1)
                                                       : cnt_cur_r - CNT_W'(1);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.new_count = out_count_r;
  assign out_ch.position  = out_pos_r;

  // chain of cells, each trading entries with its neighbours on a shift
  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    logic [ID_BITS-1:0] left_w;
    logic [ID_BITS-1:0] right_w;
    if (k == 0) begin : g_first
      assign left_w = id_r;
    end else begin : g_left
      assign left_w = ent_sel[k-1];
    end
    if (k == LIST_DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = ent_sel[k+1];
    end
    sli_cell #(
      .NUM_LISTS (NUM_LISTS),
      .ID_BITS   (ID_BITS),
      .SEL_W     (SEL_W),
      .SLOT_W    (SLOT_W),
      .IDX       (k)
    ) u_cell (
      .clk      (clk),
      .upd      (upd),
      .act      (act_r),
      .sel      (sel_r),
      .id       (id_r),
      .slot     (slot_r),
      .left_in  (left_w),
      .right_in (right_w),
      .ent_out  (ent_sel[k]),
      .hit      (hit[k])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    sel_nxt        = sel_r;
    id_nxt         = id_r;
    cnt_cur_nxt    = cnt_cur_r;
    scan_idx_nxt   = scan_idx_r;
    slot_nxt       = slot_r;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_pos_nxt    = out_pos_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      sli_pkg::S_IDLE: begin
        if (in_xfer) begin
          act_nxt      = sli_pkg::action_t'(in_ch.action);
          sel_nxt      = in_sel;
          id_nxt       = ID_BITS'(in_ch.item_id);
          cnt_cur_nxt  = in_cnt;
          scan_idx_nxt = '0;
          res_count_nxt = sli_pkg::NEW_COUNT_W'(in_cnt);
          res_pos_nxt   = '0;
          if (!sel_ok) begin
            res_status_nxt = (in_ch.action == sli_pkg::ACT_REMOVE) ?
                             sli_pkg::ST_NOT_FOUND : sli_pkg::ST_FULL;
            state_nxt = sli_pkg::S_DONE;
          end else if (in_ch.action == sli_pkg::ACT_INSERT &&
                       in_cnt >= CNT_W'(LIST_DEPTH)) begin
            res_status_nxt = sli_pkg::ST_FULL;
            state_nxt      = sli_pkg::S_DONE;
          end else begin
            state_nxt = sli_pkg::S_SCAN;
          end
        end
      end
      sli_pkg::S_SCAN: begin
        if (scan_idx_r == cnt_cur_r) begin
          if (act_r == sli_pkg::ACT_INSERT) begin
            slot_nxt  = scan_idx_r[SLOT_W-1:0];
            state_nxt = sli_pkg::S_UPDATE;
          end else begin
            res_status_nxt = sli_pkg::ST_NOT_FOUND;
            state_nxt      = sli_pkg::S_DONE;
          end
        end else if (hit_sel) begin
          slot_nxt  = scan_idx_r[SLOT_W-1:0];
          state_nxt = sli_pkg::S_UPDATE;
        end else begin
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end
      end
      sli_pkg::S_UPDATE: begin
        res_status_nxt = sli_pkg::ST_DONE;
        res_count_nxt  = sli_pkg::NEW_COUNT_W'(cnt_new);
        res_pos_nxt    = sli_pkg::POSITION_W'(slot_r);
        state_nxt      = sli_pkg::S_DONE;
      end
      sli_pkg::S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_count_nxt  = res_count_r;
          out_pos_nxt    = res_pos_r;
          state_nxt      = sli_pkg::S_IDLE;
        end
      end
      default: state_nxt = sli_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sli_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    sel_r        <= sel_nxt;
    id_r         <= id_nxt;
    cnt_cur_r    <= cnt_cur_nxt;
    scan_idx_r   <= scan_idx_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (upd) begin
      cnt_r[sel_r] <= cnt_new;
    end
  end

`ifndef ASSERT_OFF
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sli_pkg::S_SCAN |-> scan_idx_r <= cnt_cur_r)
    else $error("scan index ran past the list count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != sli_pkg::S_IDLE |-> cnt_cur_r <= CNT_W'(LIST_DEPTH))
    else $error("list count above depth");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != sli_pkg::S_IDLE)
    else $error("block idle right after an input transfer");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && act_r == sli_pkg::ACT_INSERT) |=>
      cnt_r[sel_r] == $past(cnt_cur_r) + CNT_W'(1))
    else $error("insert did not grow the list by one");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/sli_cell.sv @@
`default_nettype none

// one slot of every list: holds the entry at slot IDX of each list
module sli_cell #(
  parameter int unsigned NUM_LISTS = 3,
  parameter int unsigned ID_BITS   = 8,
  parameter int unsigned SEL_W     = 2,
  parameter int unsigned SLOT_W    = 4,
  parameter int unsigned IDX       = 0
) (
  input  wire                     clk,
  input  wire                     upd,
  input  sli_pkg::action_t        act,
  input  wire [SEL_W-1:0]         sel,
  input  wire [ID_BITS-1:0]       id,
  input  wire [SLOT_W-1:0]        slot,
  input  wire [ID_BITS-1:0]       left_in,
  input  wire [ID_BITS-1:0]       right_in,
  output logic [ID_BITS-1:0]      ent_out,
  output logic                    hit
);

  logic [ID_BITS-1:0] ent_r [NUM_LISTS];
  logic [ID_BITS-1:0] ent_nxt;
  logic [SLOT_W-1:0]  my_slot;

  assign my_slot = SLOT_W'(IDX);
  assign ent_out = ent_r[sel];

  // insert stops at the first entry above id, remove at the first equal one
  always_comb begin
    if (act == sli_pkg::ACT_INSERT) begin
      hit = (ent_out > id);
    end else begin
      hit = (ent_out == id);
    end
  end

  always_comb begin
    ent_nxt = ent_out;
    if (act == sli_pkg::ACT_INSERT) begin
      if (my_slot == slot) begin
        ent_nxt = id;
      end else if (my_slot > slot) begin
        ent_nxt = left_in;
      end
    end else if (my_slot >= slot) begin
      ent_nxt = right_in;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      ent_r[sel] <= ent_nxt;
    end
  end

endmodule

`default_nettype wire
